>>> rtl/core/greedy_coin_change_defines.svh
// Assertion macros shared by the greedy coin change checker.
// Depends on nothing; included by files that carry assertions.
`ifndef GREEDY_COIN_CHANGE_DEFINES_SVH
`define GREEDY_COIN_CHANGE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GCOIN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GCOIN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/gcoin_pkg.sv
// Shared types and constants of the greedy coin change block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package gcoin_pkg;

   localparam int COIN_W          = 16;
   localparam int AMT_W           = 16;
   localparam int SLOT_W          = 3;
   localparam int CIU_W           = 3;
   localparam int NUM_SLOTS       = 7;
   localparam int MAX_COINS_DEF   = 7;
   localparam int AMOUNT_BITS_DEF = 16;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Register index of the slot count; coin values sit at indexes zero to six.
   localparam logic [CSR_IDX_W-1:0] REG_COINS_IN_USE = 3'd7;

   localparam logic [CIU_W-1:0] COINS_IN_USE_RESET = 3'd7;

   localparam logic [COIN_W-1:0] COIN_RESET [NUM_SLOTS] = '{
      16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd1
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // take a new amount, start at slot zero
      logic step;   // one quotient bit of the current slot
      logic emit;   // write the result register, move to the next slot
   } gcoin_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;   // current slot is the last slot in use
   } gcoin_stat_type;

endpackage

>>> rtl/core/gcoin_ctrl.sv
// Controller of the greedy coin change block: sequences load, division and emit.
// Depends on gcoin_pkg.
`timescale 1ns / 1ps

module gcoin_ctrl #(
   parameter int REM_W = gcoin_pkg::AMOUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  gcoin_pkg::gcoin_stat_type stat,
   output gcoin_pkg::gcoin_cmd_type  cmd
);

   localparam int CNT_W = $clog2(REM_W);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = CNT_W'(REM_W - 1);
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step   = 1'b1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (stat.last) begin
                  state_in = ST_IDLE;
               end else begin
                  bit_cnt_in = CNT_W'(REM_W - 1);
                  state_in   = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/gcoin_dp.sv
// Datapath of the greedy coin change block: denomination registers, restoring
// divider, slot counter and result register. Depends on gcoin_pkg.
`timescale 1ns / 1ps

module gcoin_dp #(
   parameter int MAX_COINS = gcoin_pkg::MAX_COINS_DEF,
   parameter int REM_W     = gcoin_pkg::AMOUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [gcoin_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gcoin_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [gcoin_pkg::AMT_W-1:0]          amount,
   input  gcoin_pkg::gcoin_cmd_type              cmd,
   output gcoin_pkg::gcoin_stat_type             stat,
   output logic [gcoin_pkg::SLOT_W-1:0]         out_slot,
   output logic [gcoin_pkg::COIN_W-1:0]         out_count,
   output logic                                 out_last,
   output logic [gcoin_pkg::COIN_W-1:0]         out_rem
);

   localparam int COIN_W = gcoin_pkg::COIN_W;
   localparam int SLOT_W = gcoin_pkg::SLOT_W;
   localparam int IDX_W  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

   logic [COIN_W-1:0]          coin_value_ff [MAX_COINS];
   logic [gcoin_pkg::CIU_W-1:0] coins_in_use_ff;

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [REM_W-1:0]   dq_ff, dq_in;
   logic [COIN_W-1:0]  part_ff, part_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic [SLOT_W-1:0]  out_slot_ff;
   logic [COIN_W-1:0]  out_count_ff;
   logic               out_last_ff;
   logic [COIN_W-1:0]  out_rem_ff;

   logic [COIN_W-1:0]  divisor;
   logic               div_zero;
   logic [COIN_W:0]    trial;
   logic [COIN_W:0]    diff;
   logic               fits;
   logic [REM_W-1:0]   next_rem;
   logic [SLOT_W-1:0]  last_idx;
   logic               is_last;

   // Denomination registers. Slots beyond MAX_COINS are never walked.
   for (genvar i = 0; i < MAX_COINS; i++) begin : g_coin
      always_ff @(posedge clock) begin
         if (reset) begin
            coin_value_ff[i] <= gcoin_pkg::COIN_RESET[i];
         end else if (csr_wr_en && (csr_index == gcoin_pkg::CSR_IDX_W'(i))) begin
            coin_value_ff[i] <= csr_wdata[COIN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coins_in_use_ff <= gcoin_pkg::COINS_IN_USE_RESET;
      end else if (csr_wr_en && (csr_index == gcoin_pkg::REG_COINS_IN_USE)) begin
         coins_in_use_ff <= csr_wdata[gcoin_pkg::CIU_W-1:0];
      end
   end

   // A slot count of zero acts as one; a count above MAX_COINS is clipped.
   always_comb begin
      if (coins_in_use_ff == '0) begin
         last_idx = '0;
      end else if (SLOT_W'(coins_in_use_ff) > SLOT_W'(MAX_COINS)) begin
         last_idx = SLOT_W'(MAX_COINS - 1);
      end else begin
         last_idx = SLOT_W'(coins_in_use_ff) - 1'b1;
      end
   end

   assign is_last   = (slot_ff == last_idx);
   assign stat.last = is_last;

   // Restoring division: one quotient bit per step. The dividend shifts out of
   // the top of dq_ff while the quotient shifts in at the bottom.
   assign divisor  = coin_value_ff[slot_ff[IDX_W-1:0]];
   assign div_zero = (divisor == '0);
   assign trial    = {part_ff, dq_ff[REM_W-1]};
   assign diff     = trial - {1'b0, divisor};
   assign fits     = (trial >= {1'b0, divisor});

   // A zero denomination pays nothing and leaves the remainder alone.
   assign next_rem = div_zero ? rem_ff : part_ff[REM_W-1:0];

   always_comb begin
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      part_in = part_ff;
      slot_in = slot_ff;
      if (cmd.load) begin
         rem_in  = amount[REM_W-1:0];
         dq_in   = amount[REM_W-1:0];
         part_in = '0;
         slot_in = '0;
      end else if (cmd.step) begin
         part_in = fits ? diff[COIN_W-1:0] : trial[COIN_W-1:0];
         dq_in   = {dq_ff[REM_W-2:0], fits};
      end else if (cmd.emit) begin
         rem_in  = next_rem;
         dq_in   = next_rem;
         part_in = '0;
         slot_in = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      part_ff <= part_in;
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_slot_ff  <= slot_ff;
         out_count_ff <= div_zero ? '0 : COIN_W'(dq_ff);
         out_last_ff  <= is_last;
         out_rem_ff   <= is_last ? COIN_W'(next_rem) : '0;
      end
   end

   assign out_slot  = out_slot_ff;
   assign out_count = out_count_ff;
   assign out_last  = out_last_ff;
   assign out_rem   = out_rem_ff;

endmodule

>>> rtl/core/greedy_coin_change.sv
// Top level of the greedy coin change block: joins controller and datapath.
// Depends on gcoin_pkg, gcoin_ctrl and gcoin_dp.
//
//   channel  dir  beat contents
//   req_*    in   tdata: amount
//   rsp_*    out  tdata: coin_slot, coin_count, unpaid_remainder; tlast: last_slot
//   csr_*    in   write of register csr_index (0-6 coin values, 7 slot count)
//
// An amount is loaded, then each of the N slots in use is walked in turn: R steps
// of the shared restoring divider, where R = min(AMOUNT_BITS, 16), and then an
// emit step that writes the result register.
// Reset is synchronous and restores the default denominations and slot count.
// A stalled result register holds the walk in its emit step; the next amount is
// accepted as soon as the last result of the previous one is in that register.
`timescale 1ns / 1ps

module greedy_coin_change #(
   parameter int MAX_COINS   = gcoin_pkg::MAX_COINS_DEF,
   parameter int AMOUNT_BITS = gcoin_pkg::AMOUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gcoin_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [15:0] amount
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] coin_slot, [18:3] coin_count, [34:19] unpaid_remainder, [39:35] zero
   output logic [gcoin_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_wr_en,
   input  logic [gcoin_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gcoin_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int REM_W = (AMOUNT_BITS < gcoin_pkg::AMT_W) ? AMOUNT_BITS : gcoin_pkg::AMT_W;
   localparam int PAD_W = gcoin_pkg::RSP_TDATA_W - gcoin_pkg::SLOT_W - 2 * gcoin_pkg::COIN_W;

   gcoin_pkg::gcoin_cmd_type  cmd;
   gcoin_pkg::gcoin_stat_type stat;

   logic [gcoin_pkg::SLOT_W-1:0] out_slot;
   logic [gcoin_pkg::COIN_W-1:0] out_count;
   logic [gcoin_pkg::COIN_W-1:0] out_rem;

   gcoin_ctrl #(
      .REM_W (REM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gcoin_dp #(
      .MAX_COINS (MAX_COINS),
      .REM_W     (REM_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .amount    (req_tdata[gcoin_pkg::AMT_W-1:0]),
      .cmd       (cmd),
      .stat      (stat),
      .out_slot  (out_slot),
      .out_count (out_count),
      .out_last  (rsp_tlast),
      .out_rem   (out_rem)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, out_rem, out_count, out_slot};

endmodule

>>> rtl/core/gcoin_checker.sv
// Port-level checks of the greedy coin change block, bound to its top level.
// Depends on greedy_coin_change_defines.svh and greedy_coin_change.
`timescale 1ns / 1ps
`include "greedy_coin_change_defines.svh"

module gcoin_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A new amount only enters once every result but the last has left.
   `GCOIN_ASSERT_NOW(a_accept_after_walk, clock, reset,
      req_tvalid && req_tready, !(rsp_tvalid && !rsp_tlast),
      "amount accepted while results are still owed")

   // One amount at a time: the walk starts right after an accept.
   `GCOIN_ASSERT_NEXT(a_one_in_flight, clock, reset,
      req_tvalid && req_tready, !req_tready,
      "input ready right after an accepted amount")

   // The remainder is reported only on the beat that closes the walk.
   `GCOIN_ASSERT_NOW(a_rem_on_last, clock, reset,
      rsp_tvalid && !rsp_tlast, rsp_tdata[34:19] == 16'd0,
      "nonzero remainder before the last slot")

   // Padding stays zero and no slot past six is ever reported.
   `GCOIN_ASSERT_NOW(a_slot_range, clock, reset,
      rsp_tvalid, (rsp_tdata[39:35] == 5'd0) && (rsp_tdata[2:0] != 3'd7),
      "bad slot or padding in result beat")

   // A stalled result beat holds its contents.
   `GCOIN_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "stalled result beat changed")

endmodule

bind greedy_coin_change gcoin_checker u_gcoin_checker (.*);

>>> tb/sv/greedy_coin_change_checker.sv
// Scoreboard for the greedy coin change block: tracks the register file,
// predicts the per-slot payout of each accepted amount and checks every result.
// Depends on gcoin_pkg; instantiated by greedy_coin_change_test.
`timescale 1ns / 1ps

module greedy_coin_change_checker #(
   parameter int MAX_COINS   = gcoin_pkg::MAX_COINS_DEF,
   parameter int AMOUNT_BITS = gcoin_pkg::AMOUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [gcoin_pkg::REQ_TDATA_W-1:0]  req_tdata,    // [15:0] amount
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] coin_slot, [18:3] coin_count, [34:19] unpaid_remainder, [39:35] zero
   input  logic [gcoin_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [gcoin_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gcoin_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                 outstanding,
   output int                                 mismatches
);

   import gcoin_pkg::*;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [COIN_W-1:0] count;
      logic              last;
      logic [AMT_W-1:0]  remainder;
   } coin_result_t;

   localparam logic [AMT_W-1:0] AMOUNT_MASK =
      (AMOUNT_BITS >= AMT_W) ? {AMT_W{1'b1}} : AMT_W'((1 << AMOUNT_BITS) - 1);

   logic [COIN_W-1:0] coin_value [NUM_SLOTS];
   logic [CIU_W-1:0]  slot_count;
   coin_result_t      pending_results [$];

   initial begin
      outstanding = 0;
      mismatches  = 0;
   end

   // Greedy walk over the slots in use; a zero denomination pays nothing.
   function automatic void plan_payout(input logic [AMT_W-1:0] amount);
      logic [AMT_W-1:0] rest;
      int               n;
      coin_result_t     r;
      rest = amount & AMOUNT_MASK;
      n = (slot_count == '0) ? 1 : int'(slot_count);
      if (n > MAX_COINS) n = MAX_COINS;
      if (n > NUM_SLOTS) n = NUM_SLOTS;
      for (int i = 0; i < n; i++) begin
         r.slot  = SLOT_W'(i);
         r.count = '0;
         if (coin_value[i] != '0) begin
            r.count = rest / coin_value[i];
            rest    = rest - r.count * coin_value[i];
         end
         r.last      = (i == n - 1);
         r.remainder = r.last ? rest : '0;
         pending_results = {pending_results, r};
      end
   endfunction

   function automatic void check_result();
      coin_result_t want;
      if (pending_results.size() == 0) begin
         $error("result beat with no payout pending: tdata %h", rsp_tdata);
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      if (rsp_tdata[2:0] !== want.slot) begin
         $error("coin_slot: expected %0d, got %0d", want.slot, rsp_tdata[2:0]);
         mismatches++;
      end
      if (rsp_tdata[18:3] !== want.count) begin
         $error("coin_count: expected %0d, got %0d", want.count, rsp_tdata[18:3]);
         mismatches++;
      end
      if (rsp_tlast !== want.last) begin
         $error("last_slot: expected %0d, got %0d", want.last, rsp_tlast);
         mismatches++;
      end
      if (rsp_tdata[34:19] !== want.remainder) begin
         $error("unpaid_remainder: expected %0d, got %0d", want.remainder,
                rsp_tdata[34:19]);
         mismatches++;
      end
      if (rsp_tdata[39:35] !== 5'd0) begin
         $error("tdata padding: expected 0, got %0d", rsp_tdata[39:35]);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) coin_value[i] = COIN_RESET[i];
         slot_count = COINS_IN_USE_RESET;
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_COINS_IN_USE) slot_count = csr_wdata[CIU_W-1:0];
            else coin_value[csr_index] = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) plan_payout(req_tdata[AMT_W-1:0]);
      end
      outstanding = pending_results.size();
   end

endmodule

>>> tb/sv/greedy_coin_change_test.sv
// Top of the greedy coin change testbench: clock, reset, register setup,
// amount stimulus with random back-pressure, watchdog and final verdict.
// Depends on gcoin_pkg, greedy_coin_change and greedy_coin_change_checker.
`timescale 1ns / 1ps

module greedy_coin_change_test;

   import gcoin_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;    // [15:0] amount
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // [2:0] coin_slot, [18:3] coin_count, [34:19] unpaid_remainder, [39:35] zero
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   int outstanding;
   int mismatches;
   int quiet_cycles;
   int req_idle_pct;
   int rsp_idle_pct;

   logic [COIN_W-1:0] coin_table [NUM_SLOTS];
   logic [CIU_W-1:0]  slot_count;

   greedy_coin_change dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   greedy_coin_change_checker u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Any accepted beat or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("greedy_coin_change verification failed");
         $finish;
      end
   end

   // Called and returning at a falling edge; valid stays high into the next
   // beat unless an idle cycle is drawn.
   task automatic send_amount(input logic [AMT_W-1:0] amount);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= amount;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_table();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= coin_table[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b1;
      csr_index <= REG_COINS_IN_USE;
      csr_wdata <= CSR_DATA_W'(slot_count);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_table(input logic [COIN_W-1:0] v0, v1, v2, v3, v4, v5, v6,
                            input logic [CIU_W-1:0] n);
      coin_table[0] = v0;
      coin_table[1] = v1;
      coin_table[2] = v2;
      coin_table[3] = v3;
      coin_table[4] = v4;
      coin_table[5] = v5;
      coin_table[6] = v6;
      slot_count    = n;
      drain_results();
      write_table();
   endtask

   task automatic random_table(input int flavor);
      logic [COIN_W-1:0] ceiling;
      ceiling = 16'hFFFF;
      case (flavor % 4)
         0: begin
            // Descending table as software is meant to load it.
            for (int i = 0; i < NUM_SLOTS; i++) begin
               coin_table[i] = COIN_W'($urandom_range(1, ceiling));
               ceiling = coin_table[i];
            end
            slot_count = CIU_W'($urandom_range(0, 7));
         end
         1: begin
            // Arbitrary table, zero denominations included.
            for (int i = 0; i < NUM_SLOTS; i++)
               coin_table[i] = ($urandom_range(0, 9) == 0) ? '0 : COIN_W'($urandom);
            slot_count = CIU_W'($urandom_range(0, 7));
         end
         2: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               coin_table[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
            slot_count = $urandom_range(0, 1) ? 3'd7 : 3'd0;
         end
         default: begin
            // Small descending coins so that counts stay in the low range.
            ceiling = 16'd600;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               coin_table[i] = COIN_W'($urandom_range(1, ceiling));
               ceiling = coin_table[i];
            end
            slot_count = 3'd7;
         end
      endcase
      drain_results();
      write_table();
   endtask

   function automatic logic [AMT_W-1:0] pick_amount();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return AMT_W'($urandom);
      if (sel < 80) return AMT_W'($urandom_range(0, 1000));
      if (sel < 90) return AMT_W'(coin_table[0] * $urandom_range(0, 3));
      return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
   endfunction

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      rsp_tready   <= 1'b0;
      csr_wr_en    <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      quiet_cycles = 0;
      req_idle_pct = 25;
      rsp_idle_pct = 66;
      for (int i = 0; i < NUM_SLOTS; i++) coin_table[i] = COIN_RESET[i];
      slot_count = COINS_IN_USE_RESET;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset table: extremes and an amount that uses every slot.
      send_amount(16'd0);
      send_amount(16'hFFFF);
      send_amount(16'd1);
      send_amount(16'd388);
      send_amount(16'd199);

      // A slot count of zero still walks the first slot.
      set_table(16'hFFFF, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd1, 3'd0);
      send_amount(16'hFFFF);
      send_amount(16'hFFFE);
      send_amount(16'd0);

      // Zero denominations pay nothing and leave the remainder as it is.
      set_table(16'd0, 16'd7, 16'd0, 16'd3, 16'd0, 16'd0, 16'd0, 3'd7);
      send_amount(16'd100);
      send_amount(16'hFFFF);

      // Table out of order: each slot still takes the floor quotient.
      set_table(16'd3, 16'd50, 16'd1, 16'd100, 16'd2, 16'd7, 16'hFFFF, 3'd7);
      send_amount(16'd149);
      send_amount(16'hFFFF);

      // No unit coin among the slots in use: the amount cannot always be paid exactly.
      set_table(16'd25, 16'd10, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 3'd3);
      send_amount(16'd33);
      send_amount(16'd4);
      send_amount(16'd40);

      // Smallest coins everywhere: the first slot takes the whole amount.
      set_table(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 3'd7);
      send_amount(16'hFFFF);
      send_amount(16'h5555);

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin req_idle_pct = 25; rsp_idle_pct = 66; end
            1: begin req_idle_pct = 66; rsp_idle_pct = 25; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int phase = 0; phase < 4; phase++) begin
            random_table(phase + mode);
            repeat (25) begin
               if ($urandom_range(0, 19) == 0) drain_results();
               send_amount(pick_amount());
            end
         end
      end

      drain_results();
      repeat (150) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("greedy_coin_change verification clean");
      end else begin
         $display("greedy_coin_change verification failed");
      end
      $finish;
   end

endmodule
